// ===== rtl/core/sbhs_pkg.sv =====
// ----------------------------------------------------------------------------
// sbhs_pkg
// shared widths, codes and defaults for the sorted bucket hash set
// ----------------------------------------------------------------------------
package sbhs_pkg;

    localparam int DEF_NUM_BUCKETS  = 64;
    localparam int DEF_BUCKET_DEPTH = 8;

    localparam int CFG_W   = 7;
    localparam int KIND_W  = 2;
    localparam int VAL_W   = 31;
    localparam int BIDX_W  = 6;
    localparam int STAT_W  = 3;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_ABSENT    = 3'd3,
        ST_FULL      = 3'd4,
        ST_LISTED    = 3'd5,
        ST_EMPTY     = 3'd6,
        ST_RANGE     = 3'd7
    } status_t;

endpackage

// ===== rtl/core/sorted_bucket_hash_set_core.sv =====
// ----------------------------------------------------------------------------
// sorted_bucket_hash_set_core
// hash set of 31-bit values in sorted, bounded buckets chosen by value mod n
// ----------------------------------------------------------------------------
// usage
//   s_* carries one request: tuser = kind (0 insert, 1 delete, 2/3 list),
//   tdata = value [30:0], bucket [36:31]. m_* returns results: tuser = status,
//   tdata = bucket_index [5:0], entry_value [36:6], tlast on the final result.
//   cfg_we/cfg_wdata set the bucket count; write it only while idle.
//   one request at a time: s_tready is high only when the sequencer is idle.
//   insert/delete: accept, a bit-serial remainder over the 31 value bits,
//   the fill read, a read and compare per entry until one is not below the
//   value or the walk runs off the end, decide, a read and write per entry
//   shifted plus the final write, then emit; one entry access at a time.
//   list: fill read, then a read and an emit per entry; an empty bucket
//   emits after the fill read, an out-of-range one at once. after reset a
//   clearing pass zeroes the fill counts, one bucket a cycle, s_tready low.
//   the result register waits while m_tready is low; the sequencer holds until free.
// ----------------------------------------------------------------------------
module sorted_bucket_hash_set_core #(
    parameter int NUM_BUCKETS  = sbhs_pkg::DEF_NUM_BUCKETS,
    parameter int BUCKET_DEPTH = sbhs_pkg::DEF_BUCKET_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sbhs_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sbhs_pkg::S_DATA_W-1:0] s_tdata,   // value, bucket, zero pad
    input  logic [sbhs_pkg::KIND_W-1:0]   s_tuser,   // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sbhs_pkg::M_DATA_W-1:0] m_tdata,   // bucket_index, entry_value, zero pad
    output logic [sbhs_pkg::STAT_W-1:0]   m_tuser,   // status
    output logic                          m_tlast
);
    import sbhs_pkg::*;

    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int FW = $clog2(BUCKET_DEPTH + 1);
    localparam int AW = (NUM_BUCKETS * BUCKET_DEPTH > 1) ?
                        $clog2(NUM_BUCKETS * BUCKET_DEPTH) : 1;
    localparam int NE = NUM_BUCKETS * BUCKET_DEPTH;
    localparam logic [10:0]   NB_L    = 11'(NUM_BUCKETS);
    localparam logic [FW-1:0] DEPTH_L = FW'(BUCKET_DEPTH);
    localparam logic [BW-1:0] CLR_END = BW'(NUM_BUCKETS - 1);

    typedef enum logic [12:0] {
        S_CLEAR  = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_DIV    = 13'b0000000000100,
        S_FRD    = 13'b0000000001000,
        S_FLAT   = 13'b0000000010000,
        S_RD     = 13'b0000000100000,
        S_CMP    = 13'b0000001000000,
        S_DECIDE = 13'b0000010000000,
        S_SHRD   = 13'b0000100000000,
        S_SHWR   = 13'b0001000000000,
        S_LRD    = 13'b0010000000000,
        S_LDAT   = 13'b0100000000000,
        S_EMIT   = 13'b1000000000000
    } state_t;

    function automatic logic [AW-1:0] ent_addr(input logic [BW-1:0] b, input logic [FW-1:0] s);
        ent_addr = AW'(AW'(b) * AW'(BUCKET_DEPTH) + AW'(s));
    endfunction

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     cfg_reg, cfg_next;
    logic [BW-1:0]        clr_reg, clr_next;
    logic                 out_valid_reg, out_valid_next;

    logic [CFG_W-1:0]     n_reg, n_next;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [VAL_W-1:0]     val_reg, val_next;
    logic [BW-1:0]        bkt_reg, bkt_next;
    logic [CFG_W:0]       rem_reg, rem_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic [FW-1:0]        fill_reg, fill_next;
    logic [FW-1:0]        pos_reg, pos_next;
    logic [FW-1:0]        idx_reg, idx_next;
    logic                 found_reg, found_next;
    status_t              rstat_reg, rstat_next;
    logic [BIDX_W-1:0]    rbkt_reg, rbkt_next;
    logic [VAL_W-1:0]     rval_reg, rval_next;
    logic                 rlast_reg, rlast_next;
    logic                 more_reg, more_next;
    status_t              ostat_reg, ostat_next;
    logic [BIDX_W-1:0]    obkt_reg, obkt_next;
    logic [VAL_W-1:0]     oval_reg, oval_next;
    logic                 olast_reg, olast_next;

    logic [VAL_W-1:0]     ent_mem [NE];
    logic [VAL_W-1:0]     ent_q;
    logic                 ent_we, ent_re;
    logic [AW-1:0]        ent_waddr, ent_raddr;
    logic [VAL_W-1:0]     ent_wdata;
    logic [FW-1:0]        fill_mem [NUM_BUCKETS];
    logic [FW-1:0]        fill_q;
    logic                 fill_we, fill_re;
    logic [BW-1:0]        fill_waddr, fill_raddr;
    logic [FW-1:0]        fill_wdata;

    logic                 out_free;
    logic                 is_ins, is_del;
    logic [CFG_W-1:0]     n_cur;
    logic [CFG_W:0]       rem_sh, rem_new;
    logic [FW:0]          idx_inc;
    logic [FW:0]          pos_inc;

    assign out_free = !out_valid_reg || m_tready;
    assign is_ins   = (kind_reg == KIND_INSERT);
    assign is_del   = (kind_reg == KIND_DELETE);
    assign rem_sh   = {rem_reg[CFG_W-1:0], val_reg[cnt_reg]};
    assign rem_new  = (rem_sh >= {1'b0, n_reg}) ? rem_sh - {1'b0, n_reg} : rem_sh;
    assign idx_inc  = {1'b0, idx_reg} + 1'b1;
    assign pos_inc  = {1'b0, pos_reg} + 1'b1;

    always_comb
    begin
        if (cfg_reg == '0)
            n_cur = CFG_W'(1);
        else if ({4'b0, cfg_reg} > NB_L)
            n_cur = CFG_W'(NB_L);
        else
            n_cur = cfg_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        cfg_next       = cfg_we ? cfg_wdata : cfg_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        n_next         = n_reg;
        kind_next      = kind_reg;
        val_next       = val_reg;
        bkt_next       = bkt_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        fill_next      = fill_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        rstat_next     = rstat_reg;
        rbkt_next      = rbkt_reg;
        rval_next      = rval_reg;
        rlast_next     = rlast_reg;
        more_next      = more_reg;
        ostat_next     = ostat_reg;
        obkt_next      = obkt_reg;
        oval_next      = oval_reg;
        olast_next     = olast_reg;
        ent_we         = 1'b0;
        ent_re         = 1'b0;
        ent_waddr      = ent_addr(bkt_reg, pos_reg);
        ent_raddr      = ent_addr(bkt_reg, pos_reg);
        ent_wdata      = val_reg;
        fill_we        = 1'b0;
        fill_re        = 1'b0;
        fill_waddr     = bkt_reg;
        fill_raddr     = bkt_reg;
        fill_wdata     = fill_reg;
        s_tready       = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                fill_we    = 1'b1;
                fill_waddr = clr_reg;
                fill_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == CLR_END)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    kind_next = s_tuser;
                    val_next  = s_tdata[VAL_W-1:0];
                    n_next    = n_cur;
                    rem_next  = '0;
                    cnt_next  = 5'(VAL_W - 1);
                    more_next = 1'b0;
                    rbkt_next = s_tdata[VAL_W +: BIDX_W];
                    bkt_next  = BW'(s_tdata[VAL_W +: BIDX_W]);
                    if (s_tuser == KIND_INSERT || s_tuser == KIND_DELETE)
                        state_next = S_DIV;
                    else if ({1'b0, s_tdata[VAL_W +: BIDX_W]} >= n_cur)
                    begin
                        rstat_next = ST_RANGE;
                        rval_next  = '0;
                        rlast_next = 1'b1;
                        state_next = S_EMIT;
                    end
                    else
                        state_next = S_FRD;
                end
            end
            S_DIV:
            begin
                rem_next = rem_new;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    bkt_next   = BW'(rem_new);
                    rbkt_next  = BIDX_W'(rem_new);
                    state_next = S_FRD;
                end
            end
            S_FRD:
            begin
                fill_re    = 1'b1;
                state_next = S_FLAT;
            end
            S_FLAT:
            begin
                fill_next = fill_q;
                pos_next  = '0;
                if (is_ins || is_del)
                    state_next = S_RD;
                else if (fill_q == '0)
                begin
                    rstat_next = ST_EMPTY;
                    rval_next  = '0;
                    rlast_next = 1'b1;
                    state_next = S_EMIT;
                end
                else
                    state_next = S_LRD;
            end
            S_RD:
            begin
                if (pos_reg < fill_reg)
                begin
                    ent_re     = 1'b1;
                    state_next = S_CMP;
                end
                else
                begin
                    found_next = 1'b0;
                    state_next = S_DECIDE;
                end
            end
            S_CMP:
            begin
                if (ent_q < val_reg)
                begin
                    pos_next   = FW'(pos_inc);
                    state_next = S_RD;
                end
                else
                begin
                    found_next = (ent_q == val_reg);
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                rval_next  = val_reg;
                rlast_next = 1'b1;
                if (is_ins)
                begin
                    if (found_reg)
                    begin
                        rstat_next = ST_DUPLICATE;
                        state_next = S_EMIT;
                    end
                    else if (fill_reg >= DEPTH_L)
                    begin
                        rstat_next = ST_FULL;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        idx_next   = fill_reg;
                        state_next = S_SHRD;
                    end
                end
                else if (found_reg)
                begin
                    idx_next   = pos_reg;
                    state_next = S_SHRD;
                end
                else
                begin
                    rstat_next = ST_ABSENT;
                    state_next = S_EMIT;
                end
            end
            S_SHRD:
            begin
                if (is_ins)
                begin
                    if (idx_reg == pos_reg)
                    begin
                        ent_we     = 1'b1;
                        fill_we    = 1'b1;
                        fill_wdata = fill_reg + 1'b1;
                        rstat_next = ST_INSERTED;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        ent_re     = 1'b1;
                        ent_raddr  = ent_addr(bkt_reg, idx_reg - 1'b1);
                        state_next = S_SHWR;
                    end
                end
                else if (idx_inc >= {1'b0, fill_reg})
                begin
                    fill_we    = 1'b1;
                    fill_wdata = fill_reg - 1'b1;
                    rstat_next = ST_REMOVED;
                    state_next = S_EMIT;
                end
                else
                begin
                    ent_re     = 1'b1;
                    ent_raddr  = ent_addr(bkt_reg, FW'(idx_inc));
                    state_next = S_SHWR;
                end
            end
            S_SHWR:
            begin
                ent_we     = 1'b1;
                ent_waddr  = ent_addr(bkt_reg, idx_reg);
                ent_wdata  = ent_q;
                idx_next   = is_ins ? idx_reg - 1'b1 : FW'(idx_inc);
                state_next = S_SHRD;
            end
            S_LRD:
            begin
                ent_re     = 1'b1;
                state_next = S_LDAT;
            end
            S_LDAT:
            begin
                rstat_next = ST_LISTED;
                rval_next  = ent_q;
                rlast_next = (pos_inc == {1'b0, fill_reg});
                more_next  = (pos_inc != {1'b0, fill_reg});
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ostat_next     = rstat_reg;
                    obkt_next      = rbkt_reg;
                    oval_next      = rval_reg;
                    olast_next     = rlast_reg;
                    if (more_reg)
                    begin
                        pos_next   = FW'(pos_inc);
                        state_next = S_LRD;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cfg_reg       <= CFG_RESET;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        kind_reg  <= kind_next;
        val_reg   <= val_next;
        bkt_reg   <= bkt_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        fill_reg  <= fill_next;
        pos_reg   <= pos_next;
        idx_reg   <= idx_next;
        found_reg <= found_next;
        rstat_reg <= rstat_next;
        rbkt_reg  <= rbkt_next;
        rval_reg  <= rval_next;
        rlast_reg <= rlast_next;
        more_reg  <= more_next;
        ostat_reg <= ostat_next;
        obkt_reg  <= obkt_next;
        oval_reg  <= oval_next;
        olast_reg <= olast_next;
    end

    // entry store, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_waddr] <= ent_wdata;
        if (ent_re)
            ent_q <= ent_mem[ent_raddr];
    end

    // fill counts, zeroed by the clearing pass
    always_ff @(posedge clk)
    begin
        if (fill_we)
            fill_mem[fill_waddr] <= fill_wdata;
        if (fill_re)
            fill_q <= fill_mem[fill_raddr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = ostat_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {{(M_DATA_W - BIDX_W - VAL_W){1'b0}}, oval_reg, obkt_reg};

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in progress");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_we |-> fill_wdata <= DEPTH_L)
        else $error("bucket fill beyond depth");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT && out_free |=> m_tvalid)
        else $error("result lost on emit");

endmodule

// ===== dv/sbhs_checker.sv =====
// ----------------------------------------------------------------------------
// sbhs_checker
// watches the request and result streams of the sorted bucket hash set,
// keeps its own copy of the buckets and compares every result in order
// ----------------------------------------------------------------------------
module sbhs_checker
    import sbhs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [KIND_W-1:0]   s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic [STAT_W-1:0]   m_tuser,
    input  logic                m_tlast,
    output int                  errors,
    output int                  pending,
    output int                  n_requests,
    output int                  n_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = DEF_NUM_BUCKETS;
    localparam int DEPTH = DEF_BUCKET_DEPTH;

    typedef struct packed {
        status_t            st;
        logic [BIDX_W-1:0]  bidx;
        logic [VAL_W-1:0]   entry;
        logic               last;
    } hash_result_t;

    hash_result_t        result_q[$];
    logic [VAL_W-1:0]    bucket_vals[NB][DEPTH];
    int                  bucket_len[NB];
    logic [CFG_W-1:0]    modulus_reg;

    assign pending = result_q.size();

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, n_results);
        errors++;
    endtask

    function automatic int live_buckets();
        if (modulus_reg == 0)
            return 1;
        if (modulus_reg > NB)
            return NB;
        return int'(modulus_reg);
    endfunction

    function automatic hash_result_t mk(status_t st, int b, logic [VAL_W-1:0] v, logic l);
        hash_result_t r;
        r.st = st;
        r.bidx = BIDX_W'(b);
        r.entry = v;
        r.last = l;
        return r;
    endfunction

    task automatic queue_result(input hash_result_t r);
        result_q.insert(result_q.size(), r);
    endtask

    task automatic apply_request(input logic [KIND_W-1:0] kind, input logic [VAL_W-1:0] v,
                                 input logic [BIDX_W-1:0] req);
        int n;
        int b;
        int len;
        int pos;
        n = live_buckets();
        if (kind == KIND_INSERT || kind == KIND_DELETE)
        begin
            b = int'(v % n);
            len = bucket_len[b];
            pos = 0;
            while (pos < len && bucket_vals[b][pos] < v)
                pos++;
            if (kind == KIND_INSERT)
            begin
                if (pos < len && bucket_vals[b][pos] == v)
                    queue_result(mk(ST_DUPLICATE, b, v, 1'b1));
                else if (len >= DEPTH)
                    queue_result(mk(ST_FULL, b, v, 1'b1));
                else
                begin
                    for (int i = len; i > pos; i--)
                        bucket_vals[b][i] = bucket_vals[b][i-1];
                    bucket_vals[b][pos] = v;
                    bucket_len[b] = len + 1;
                    queue_result(mk(ST_INSERTED, b, v, 1'b1));
                end
            end
            else if (pos < len && bucket_vals[b][pos] == v)
            begin
                for (int i = pos; i + 1 < len; i++)
                    bucket_vals[b][i] = bucket_vals[b][i+1];
                bucket_len[b] = len - 1;
                queue_result(mk(ST_REMOVED, b, v, 1'b1));
            end
            else
                queue_result(mk(ST_ABSENT, b, v, 1'b1));
        end
        else if (int'(req) >= n)
            queue_result(mk(ST_RANGE, int'(req), '0, 1'b1));
        else if (bucket_len[req] == 0)
            queue_result(mk(ST_EMPTY, int'(req), '0, 1'b1));
        else
            for (int i = 0; i < bucket_len[req]; i++)
                queue_result(mk(ST_LISTED, int'(req), bucket_vals[req][i],
                                i + 1 == bucket_len[req]));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_q.delete();
            foreach (bucket_len[i])
                bucket_len[i] = 0;
            modulus_reg = CFG_RESET;
            errors = 0;
            n_requests = 0;
            n_results = 0;
        end
        else
        begin
            if (cfg_we)
                modulus_reg = cfg_wdata;
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                    report("unexpected result", {m_tuser, m_tdata}, '0);
                else
                begin
                    hash_result_t want;
                    want = result_q.pop_front();
                    if (m_tuser != want.st)
                        report("status", m_tuser, want.st);
                    if (m_tdata[BIDX_W-1:0] != want.bidx)
                        report("bucket_index", m_tdata[BIDX_W-1:0], want.bidx);
                    if (m_tdata[BIDX_W +: VAL_W] != want.entry)
                        report("entry_value", m_tdata[BIDX_W +: VAL_W], want.entry);
                    if (m_tlast != want.last)
                        report("last", m_tlast, want.last);
                end
                n_results++;
            end
            if (s_tvalid && s_tready)
            begin
                apply_request(s_tuser, s_tdata[VAL_W-1:0], s_tdata[VAL_W +: BIDX_W]);
                n_requests++;
            end
        end
    end

endmodule

// ===== dv/tb_sorted_bucket_hash_set_core.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_bucket_hash_set_core
// drives inserts, deletes and bucket listings through the hash set under
// several bucket counts with random gaps and back-pressure; results are
// checked by sbhs_checker
// ----------------------------------------------------------------------------
module tb_sorted_bucket_hash_set_core;
    import sbhs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [KIND_W-1:0] KIND_LIST = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;   // value, bucket, zero pad
    logic [KIND_W-1:0]   s_tuser = '0;   // kind
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;        // bucket_index, entry_value, zero pad
    logic [STAT_W-1:0]   m_tuser;        // status
    logic                m_tlast;

    int errors, pending, n_requests, n_results;
    int cycles = 0;
    int live_n = 64;
    logic [VAL_W-1:0] recent[16];
    int recent_wr = 0;

    sorted_bucket_hash_set_core u_top (.*);

    sbhs_checker u_checker (.*);

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side back-pressure: free-running stretches, short stalls, rare long ones
    initial
    begin
        int run;
        int stall;
        @(posedge clk);
        forever
        begin
            run = $urandom_range(0, 9) == 0 ? $urandom_range(30, 120) : $urandom_range(1, 8);
            m_tready <= 1'b1;
            repeat (run) @(posedge clk);
            stall = $urandom_range(0, 19) == 0 ? $urandom_range(15, 40) : $urandom_range(1, 3);
            m_tready <= 1'b0;
            repeat (stall) @(posedge clk);
        end
    end

    task automatic send(input logic [KIND_W-1:0] kind, input logic [VAL_W-1:0] v,
                        input logic [BIDX_W-1:0] bkt);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {3'b000, bkt, v};
        do
            @(posedge clk);
        while (!s_tready);
        if (kind == KIND_INSERT)
        begin
            recent[recent_wr] = v;
            recent_wr = (recent_wr + 1) % 16;
        end
        gap = $urandom_range(0, 2) == 0 ? 0 :
              ($urandom_range(0, 14) == 0 ? $urandom_range(10, 30) : $urandom_range(1, 3));
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_buckets(input logic [CFG_W-1:0] n);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= n;
        @(posedge clk);
        cfg_we <= 1'b0;
        live_n = n == 0 ? 1 : (n > 64 ? 64 : int'(n));
    endtask

    task automatic random_request();
        logic [VAL_W-1:0] v;
        int pick;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            v = VAL_W'($urandom_range(0, 300));
        else if (sel < 7)
            v = recent[$urandom_range(0, 15)];
        else
            v = VAL_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 45)
            send(KIND_INSERT, v, BIDX_W'($urandom));
        else if (pick < 72)
            send(KIND_DELETE, v, BIDX_W'($urandom));
        else
            send($urandom_range(0, 3) == 0 ? KIND_SPARE : KIND_LIST, VAL_W'($urandom),
                 $urandom_range(0, 1) ? BIDX_W'($urandom_range(0, live_n - 1))
                                      : BIDX_W'($urandom));
    endtask

    initial
    begin
        logic [CFG_W-1:0] phases[9] = '{7'd64, 7'd1, 7'd7, 7'd3, 7'd127, 7'd0, 7'd13, 7'd65, 7'd2};
        foreach (recent[i])
            recent[i] = VAL_W'(i);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, duplicates, deletes, lists, spare kind
        send(KIND_LIST, '0, 6'd0);
        send(KIND_INSERT, '0, '0);
        send(KIND_INSERT, {VAL_W{1'b1}}, '1);
        send(KIND_INSERT, {VAL_W{1'b1}}, '0);
        send(KIND_DELETE, 31'd5, '0);
        send(KIND_INSERT, 31'd127, '0);
        send(KIND_LIST, '1, 6'd63);
        send(KIND_SPARE, '0, 6'd63);
        send(KIND_DELETE, {VAL_W{1'b1}}, '0);
        send(KIND_DELETE, '0, '0);

        // single bucket: fill, overflow, duplicate while full, out-of-range list
        set_buckets(7'd1);
        for (int i = 9; i >= 1; i--)
            send(KIND_INSERT, VAL_W'(i * 3), '0);
        send(KIND_INSERT, 31'd12, '0);
        send(KIND_LIST, '0, 6'd0);
        send(KIND_LIST, '0, 6'd5);
        send(KIND_DELETE, 31'd13, '0);
        send(KIND_DELETE, 31'd3, '0);
        send(KIND_LIST, '0, 6'd0);

        foreach (phases[p])
        begin
            set_buckets(phases[p]);
            for (int i = 0; i < 50; i++)
            begin
                random_request();
                if (i == 25 && (p % 3) == 0)
                    drain();
            end
        end

        drain();
        repeat (100) @(posedge clk);
        $display("covered %0d requests and %0d results over bucket counts 0 to 127",
                 n_requests, n_results);
        $display("with full, duplicate, empty and out-of-range buckets under back-pressure");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
